// ----- rtl/arap_pkg.sv -----
// ----------------------------------------------------------------------------
// Aspect ratio attribute parser package
// Shared phase type, parse state record, characters and keyword tables.
// ----------------------------------------------------------------------------
package arap_pkg;

  localparam int unsigned CodeW  = 16;
  localparam int unsigned AlignW = 4;
  localparam int unsigned PosW   = 3;

  localparam logic [AlignW-1:0] ALIGN_NONE     = 4'd0;
  localparam logic [AlignW-1:0] ALIGN_XMIDYMID = 4'd5;

  typedef enum logic [3:0] {
    PH_LEAD        = 4'd0,
    PH_DEFER       = 4'd1,
    PH_AFTER_DEFER = 4'd2,
    PH_NONE        = 4'd3,
    PH_ALIGN       = 4'd4,
    PH_AFTER_ALIGN = 4'd5,
    PH_MEET        = 4'd6,
    PH_SLICE       = 4'd7,
    PH_TRAIL       = 4'd8
  } phase_e;

  typedef struct packed {
    phase_e            phase;
    logic [PosW-1:0]   pos;
    logic [AlignW-1:0] align;
    logic              slice;
    logic              failed;
  } parse_state_t;

  localparam parse_state_t PARSE_RESET = '{
    phase:  PH_LEAD,
    pos:    '0,
    align:  ALIGN_NONE,
    slice:  1'b0,
    failed: 1'b0
  };

  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_LO_D  = 8'h64;
  localparam logic [7:0] CH_LO_I  = 8'h69;
  localparam logic [7:0] CH_LO_M  = 8'h6D;
  localparam logic [7:0] CH_LO_N  = 8'h6E;
  localparam logic [7:0] CH_LO_S  = 8'h73;
  localparam logic [7:0] CH_LO_X  = 8'h78;
  localparam logic [7:0] CH_UP_M  = 8'h4D;
  localparam logic [7:0] CH_UP_Y  = 8'h59;

  function automatic logic is_space(input logic [CodeW-1:0] c);
    return (c == {8'h00, CH_SPACE}) || (c == {8'h00, CH_TAB}) ||
           (c == {8'h00, CH_LF})    || (c == {8'h00, CH_CR});
  endfunction

  function automatic logic is_char(input logic [CodeW-1:0] c, input logic [7:0] ch);
    return c == {8'h00, ch};
  endfunction

  // Length of the keyword matched in a given phase.
  function automatic logic [PosW-1:0] word_len(input phase_e ph);
    logic [PosW-1:0] len;
    len = '0;
    case (ph)
      PH_DEFER: len = 3'd5;
      PH_NONE:  len = 3'd4;
      PH_MEET:  len = 3'd4;
      PH_SLICE: len = 3'd5;
      default:  len = '0;
    endcase
    return len;
  endfunction

  // Character at a position of the keyword matched in a given phase.
  function automatic logic [7:0] word_char(input phase_e ph, input logic [PosW-1:0] pos);
    logic [39:0] word;
    logic [7:0]  ch;
    word = '0;
    ch   = '0;
    case (ph)
      PH_DEFER: word = "defer";
      PH_NONE:  word = {"none", 8'h00};
      PH_MEET:  word = {"meet", 8'h00};
      PH_SLICE: word = "slice";
      default:  word = '0;
    endcase
    case (pos)
      3'd0:    ch = word[39:32];
      3'd1:    ch = word[31:24];
      3'd2:    ch = word[23:16];
      3'd3:    ch = word[15:8];
      3'd4:    ch = word[7:0];
      default: ch = '0;
    endcase
    return ch;
  endfunction

  // Phase entered when a keyword completes.
  function automatic phase_e word_next(input phase_e ph);
    phase_e nxt;
    case (ph)
      PH_DEFER: nxt = PH_AFTER_DEFER;
      PH_NONE:  nxt = PH_AFTER_ALIGN;
      default:  nxt = PH_TRAIL;
    endcase
    return nxt;
  endfunction

endpackage

// ----- rtl/arap_step.sv -----
// ----------------------------------------------------------------------------
// Aspect ratio attribute parser step
// Advances the parse state by one code unit and forms the pending result.
// ----------------------------------------------------------------------------
module arap_step (
  input  arap_pkg::parse_state_t           cur_i,
  input  logic [arap_pkg::CodeW-1:0]       code_i,
  input  logic                             has_char_i,
  output arap_pkg::parse_state_t           nxt_o,
  output logic [arap_pkg::AlignW-1:0]      align_o,
  output logic                             slice_o
);
  import arap_pkg::*;

  parse_state_t      nxt;
  parse_state_t      eff;
  logic              sp;
  logic              aok;
  logic [AlignW-1:0] aval;
  logic [PosW-1:0]   pos_inc;
  logic [PosW-1:0]   len;
  logic              ok;

  assign sp      = is_space(code_i);
  assign pos_inc = cur_i.pos + 3'd1;
  assign len     = word_len(cur_i.phase);

  always_comb begin
    nxt  = cur_i;
    aok  = 1'b0;
    aval = cur_i.align;
    if (!cur_i.failed) begin
      case (cur_i.phase)
        PH_LEAD, PH_AFTER_DEFER: begin
          if (!sp) begin
            if (cur_i.phase == PH_LEAD && is_char(code_i, CH_LO_D)) begin
              nxt.phase = PH_DEFER;
              nxt.pos   = 3'd1;
            end else if (is_char(code_i, CH_LO_N)) begin
              nxt.phase = PH_NONE;
              nxt.pos   = 3'd1;
              nxt.align = ALIGN_NONE;
            end else if (is_char(code_i, CH_LO_X)) begin
              nxt.phase = PH_ALIGN;
              nxt.pos   = 3'd1;
              nxt.align = ALIGN_NONE;
            end else begin
              nxt.failed = 1'b1;
            end
          end
        end
        PH_DEFER, PH_NONE, PH_MEET, PH_SLICE: begin
          if (cur_i.pos < len && is_char(code_i, word_char(cur_i.phase, cur_i.pos))) begin
            if (pos_inc >= len) begin
              nxt.pos   = '0;
              nxt.phase = word_next(cur_i.phase);
              if (cur_i.phase == PH_SLICE) begin
                nxt.slice = (cur_i.align != ALIGN_NONE);
              end
            end else begin
              nxt.pos = pos_inc;
            end
          end else begin
            nxt.failed = 1'b1;
          end
        end
        PH_ALIGN: begin
          case (cur_i.pos)
            3'd1, 3'd5: aok = is_char(code_i, CH_UP_M);
            3'd4:       aok = is_char(code_i, CH_UP_Y);
            3'd2, 3'd6: begin
              if (is_char(code_i, CH_LO_I)) begin
                aok = 1'b1;
              end else if (is_char(code_i, CH_LO_A)) begin
                aok  = 1'b1;
                aval = cur_i.align + ((cur_i.pos == 3'd2) ? 4'd3 : 4'd6);
              end
            end
            3'd3: begin
              if (cur_i.align == 4'd0 && is_char(code_i, CH_LO_N)) begin
                aok  = 1'b1;
                aval = 4'd0;
              end else if (cur_i.align == 4'd0 && is_char(code_i, CH_LO_D)) begin
                aok  = 1'b1;
                aval = 4'd1;
              end else if (cur_i.align == 4'd3 && is_char(code_i, CH_LO_X)) begin
                aok  = 1'b1;
                aval = 4'd2;
              end
            end
            default: begin
              if (cur_i.align < 4'd3 && is_char(code_i, CH_LO_N)) begin
                aok  = 1'b1;
                aval = cur_i.align + 4'd1;
              end else if (cur_i.align < 4'd3 && is_char(code_i, CH_LO_D)) begin
                aok  = 1'b1;
                aval = cur_i.align + 4'd4;
              end else if (cur_i.align >= 4'd6 && is_char(code_i, CH_LO_X)) begin
                aok  = 1'b1;
                aval = cur_i.align + 4'd1;
              end
            end
          endcase
          if (aok) begin
            nxt.align = aval;
            nxt.pos   = pos_inc;
            if (pos_inc == '0) begin
              nxt.phase = PH_AFTER_ALIGN;
            end
          end else begin
            nxt.failed = 1'b1;
          end
        end
        PH_AFTER_ALIGN: begin
          if (!sp) begin
            if (is_char(code_i, CH_LO_M)) begin
              nxt.phase = PH_MEET;
              nxt.pos   = 3'd1;
            end else if (is_char(code_i, CH_LO_S)) begin
              nxt.phase = PH_SLICE;
              nxt.pos   = 3'd1;
            end else begin
              nxt.failed = 1'b1;
            end
          end
        end
        PH_TRAIL: begin
          if (!sp) begin
            nxt.failed = 1'b1;
          end
        end
        default: nxt.failed = 1'b1;
      endcase
    end
  end

  assign eff     = has_char_i ? nxt : cur_i;
  assign nxt_o   = eff;
  assign ok      = !eff.failed && (eff.phase == PH_AFTER_ALIGN || eff.phase == PH_TRAIL);
  assign align_o = ok ? eff.align : ALIGN_NONE;
  assign slice_o = ok ? eff.slice : 1'b0;

endmodule

// ----- rtl/aspect_ratio_attribute_parser.sv -----
// ----------------------------------------------------------------------------
// Aspect ratio attribute parser
// Parses a preserve-aspect-ratio attribute string, one code unit per request,
// and reports the alignment, the slice flag and a change flag at its end.
//
//   Channel   Dir  Handshake                    Payload
//   s_axis    in   s_axis_tvalid/s_axis_tready  tdata code_unit, tuser has_char,
//                                               tlast last
//   m_axis    out  m_axis_tvalid/m_axis_tready  tdata alignment, slice, changed
//
// A request enters an input register and is parsed from there; a string's
// result is loaded into the output register. One request is taken every
// cycle while the input side does not stall; parse_q closes the state loop.
// After reset the stored pair is xMidYMid/meet and the parser is idle.
// A held result stalls the parse stage, and the input side stalls only when
// the input register is full and the parse stage cannot advance.
// ----------------------------------------------------------------------------
module aspect_ratio_attribute_parser (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,   // [15:0] code_unit
  input  logic        s_axis_tuser,   // [0] has_char
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata    // [3:0] alignment, [4] slice, [5] changed, [7:6] zero
);
  import arap_pkg::*;

  logic              in_valid_q, in_valid_d;
  logic [CodeW-1:0]  in_code_q;
  logic              in_has_q;
  logic              in_last_q;
  logic              advance;
  logic              out_load;

  parse_state_t      parse_q, parse_d;
  parse_state_t      step_nxt;
  logic [AlignW-1:0] step_align;
  logic              step_slice;

  logic [AlignW-1:0] stored_align_q, stored_align_d;
  logic              stored_slice_q, stored_slice_d;

  logic              out_valid_q, out_valid_d;
  logic [AlignW-1:0] out_align_q;
  logic              out_slice_q;
  logic              out_changed_q;

  assign advance       = !out_valid_q || m_axis_tready;
  assign s_axis_tready = !in_valid_q || advance;
  assign out_load      = advance && in_valid_q && in_last_q;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_axis_tready) begin
      in_valid_d = s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_code_q <= s_axis_tdata;
      in_has_q  <= s_axis_tuser;
      in_last_q <= s_axis_tlast;
    end
  end

  arap_step u_step (
    .cur_i      (parse_q),
    .code_i     (in_code_q),
    .has_char_i (in_has_q),
    .nxt_o      (step_nxt),
    .align_o    (step_align),
    .slice_o    (step_slice)
  );

  always_comb begin
    parse_d        = parse_q;
    stored_align_d = stored_align_q;
    stored_slice_d = stored_slice_q;
    if (advance && in_valid_q) begin
      if (in_last_q) begin
        parse_d        = PARSE_RESET;
        stored_align_d = step_align;
        stored_slice_d = step_slice;
      end else begin
        parse_d = step_nxt;
      end
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      parse_q        <= PARSE_RESET;
      stored_align_q <= ALIGN_XMIDYMID;
      stored_slice_q <= 1'b0;
      out_valid_q    <= 1'b0;
    end else begin
      parse_q        <= parse_d;
      stored_align_q <= stored_align_d;
      stored_slice_q <= stored_slice_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_align_q   <= step_align;
      out_slice_q   <= step_slice;
      out_changed_q <= (step_align != stored_align_q) || (step_slice != stored_slice_q);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {2'b00, out_changed_q, out_slice_q, out_align_q};

  // The alignment code of a result never exceeds the last defined token.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (out_align_q <= 4'd9))
    else $error("alignment code out of range");

  // Slice is only reported together with a real alignment.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && out_slice_q |-> (out_align_q != ALIGN_NONE))
    else $error("slice reported with alignment none");

  // The stored pair follows the result that was just loaded.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (stored_align_q == out_align_q) && (stored_slice_q == out_slice_q))
    else $error("stored pair does not match emitted result");

  // The end of a string returns the parser to its idle state.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_load |=> (parse_q == PARSE_RESET))
    else $error("parse state not cleared after end of string");

  // A failure sticks until the string ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    parse_q.failed && !out_load |=> parse_q.failed)
    else $error("parse failure dropped before end of string");

endmodule

// ----- test/arap_checker.sv -----
// ----------------------------------------------------------------------------
// Aspect ratio parser checker
// Watches both stream channels of the aspect ratio attribute parser. It keeps
// its own parse state, predicts the alignment, slice and change flags of each
// string, and compares them with the results in arrival order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module arap_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [arap_pkg::CodeW-1:0] s_axis_tdata,
  input  logic                       s_axis_tuser,
  input  logic                       s_axis_tlast,
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [7:0]                 m_axis_tdata,
  output int unsigned                fail_count_o,
  output int unsigned                pending_o
);
  import arap_pkg::*;

  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [AlignW-1:0] alignment;
    logic              slice;
    logic              changed;
  } aspect_result_t;

  aspect_result_t    aspect_expected_q[$];
  aspect_result_t    got_result;
  aspect_result_t    want_result;
  aspect_result_t    new_result;
  logic              string_ok;

  phase_e            cur_phase;
  logic [PosW-1:0]   tok_pos;
  logic [AlignW-1:0] part_align;
  logic              part_slice;
  logic              parse_bad;
  logic [AlignW-1:0] held_align;
  logic              held_slice;

  function automatic logic is_blank(input logic [CodeW-1:0] c);
    return c == 16'h0020 || c == 16'h0009 || c == 16'h000A || c == 16'h000D;
  endfunction

  function automatic void restart_parse();
    cur_phase  = PH_LEAD;
    tok_pos    = '0;
    part_align = ALIGN_NONE;
    part_slice = 1'b0;
    parse_bad  = 1'b0;
  endfunction

  function automatic void open_alignment(input logic [CodeW-1:0] c);
    if (c == "n") begin
      cur_phase  = PH_NONE;
      tok_pos    = 3'd1;
      part_align = ALIGN_NONE;
    end else if (c == "x") begin
      cur_phase  = PH_ALIGN;
      tok_pos    = 3'd1;
      part_align = ALIGN_NONE;
    end else begin
      parse_bad = 1'b1;
    end
  endfunction

  function automatic void keyword_step(input string kw, input logic [CodeW-1:0] c,
                                       input phase_e nxt);
    if (tok_pos < kw.len() && c == {8'h00, kw[tok_pos]}) begin
      tok_pos = tok_pos + 3'd1;
      if (tok_pos >= kw.len()) begin
        tok_pos   = '0;
        cur_phase = nxt;
      end
    end else begin
      parse_bad = 1'b1;
    end
  endfunction

  function automatic void alignment_step(input logic [CodeW-1:0] c);
    logic ok;
    ok = 1'b0;
    case (tok_pos)
      3'd1, 3'd5: ok = (c == "M");
      3'd4:       ok = (c == "Y");
      3'd2, 3'd6: begin
        if (c == "i") begin
          ok = 1'b1;
        end else if (c == "a") begin
          ok = 1'b1;
          part_align = part_align + ((tok_pos == 3'd2) ? 4'd3 : 4'd6);
        end
      end
      3'd3: begin
        if (part_align == 4'd0 && c == "n") begin
          ok = 1'b1;
          part_align = 4'd0;
        end else if (part_align == 4'd0 && c == "d") begin
          ok = 1'b1;
          part_align = 4'd1;
        end else if (part_align == 4'd3 && c == "x") begin
          ok = 1'b1;
          part_align = 4'd2;
        end
      end
      default: begin
        if (part_align < 4'd3 && c == "n") begin
          ok = 1'b1;
          part_align = part_align + 4'd1;
        end else if (part_align < 4'd3 && c == "d") begin
          ok = 1'b1;
          part_align = part_align + 4'd4;
        end else if (part_align >= 4'd6 && c == "x") begin
          ok = 1'b1;
          part_align = part_align + 4'd1;
        end
      end
    endcase
    if (!ok) begin
      parse_bad = 1'b1;
    end else begin
      tok_pos = tok_pos + 3'd1;
      if (tok_pos == '0) begin
        cur_phase = PH_AFTER_ALIGN;
      end
    end
  endfunction

  function automatic void consume_unit(input logic [CodeW-1:0] c);
    if (!parse_bad) begin
      case (cur_phase)
        PH_LEAD: begin
          if (!is_blank(c)) begin
            if (c == "d") begin
              cur_phase = PH_DEFER;
              tok_pos   = 3'd1;
            end else begin
              open_alignment(c);
            end
          end
        end
        PH_DEFER:       keyword_step("defer", c, PH_AFTER_DEFER);
        PH_AFTER_DEFER: if (!is_blank(c)) open_alignment(c);
        PH_NONE:        keyword_step("none", c, PH_AFTER_ALIGN);
        PH_ALIGN:       alignment_step(c);
        PH_AFTER_ALIGN: begin
          if (!is_blank(c)) begin
            if (c == "m") begin
              cur_phase = PH_MEET;
              tok_pos   = 3'd1;
            end else if (c == "s") begin
              cur_phase = PH_SLICE;
              tok_pos   = 3'd1;
            end else begin
              parse_bad = 1'b1;
            end
          end
        end
        PH_MEET:        keyword_step("meet", c, PH_TRAIL);
        PH_SLICE: begin
          keyword_step("slice", c, PH_TRAIL);
          if (cur_phase == PH_TRAIL && !parse_bad) begin
            part_slice = (part_align != ALIGN_NONE);
          end
        end
        PH_TRAIL:       if (!is_blank(c)) parse_bad = 1'b1;
        default:        parse_bad = 1'b1;
      endcase
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      restart_parse();
      held_align = ALIGN_XMIDYMID;
      held_slice = 1'b0;
      aspect_expected_q.delete();
      fail_count_o = 0;
      pending_o    = 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got_result.alignment = m_axis_tdata[3:0];
        got_result.slice     = m_axis_tdata[4];
        got_result.changed   = m_axis_tdata[5];
        if (aspect_expected_q.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= ReportLimit) begin
            $display("%0t: unexpected result align=%0d slice=%0b changed=%0b", $realtime,
                     got_result.alignment, got_result.slice, got_result.changed);
          end
        end else begin
          want_result = aspect_expected_q.pop_front();
          if (got_result.alignment !== want_result.alignment ||
              got_result.slice !== want_result.slice ||
              got_result.changed !== want_result.changed) begin
            fail_count_o++;
            if (fail_count_o <= ReportLimit) begin
              $display({"%0t: mismatch align exp=%0d got=%0d slice exp=%0b got=%0b",
                        " changed exp=%0b got=%0b"},
                       $realtime, want_result.alignment, got_result.alignment,
                       want_result.slice, got_result.slice,
                       want_result.changed, got_result.changed);
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        if (s_axis_tuser) begin
          consume_unit(s_axis_tdata);
        end
        if (s_axis_tlast) begin
          string_ok = !parse_bad && (cur_phase == PH_AFTER_ALIGN || cur_phase == PH_TRAIL);
          new_result.alignment = string_ok ? part_align : ALIGN_NONE;
          new_result.slice     = string_ok ? part_slice : 1'b0;
          new_result.changed   = (new_result.alignment != held_align) ||
                                 (new_result.slice != held_slice);
          aspect_expected_q.push_back(new_result);
          held_align = new_result.alignment;
          held_slice = new_result.slice;
          restart_parse();
        end
      end
      pending_o = aspect_expected_q.size();
    end
  end

endmodule

// ----- test/tb_top.sv -----
// ----------------------------------------------------------------------------
// Aspect ratio parser testbench
// Streams attribute strings into the parser: a few directed strings, then
// random well-formed strings with random content, corrupted strings and
// noise, with random gaps and back-pressure. A checker beside the block
// predicts and compares the results; this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
  import arap_pkg::*;

  localparam int unsigned NumItems    = 1300;
  localparam int unsigned IdleLimit   = 1000;
  localparam int unsigned DrainCycles = 20;

  logic              clk_i;
  logic              rst_ni;
  logic              s_axis_tvalid;
  logic              s_axis_tready;
  logic [CodeW-1:0]  s_axis_tdata;
  logic              s_axis_tuser;
  logic              s_axis_tlast;
  logic              m_axis_tvalid;
  logic              m_axis_tready;
  logic [7:0]        m_axis_tdata;

  int unsigned       fail_count;
  int unsigned       pending_count;
  int unsigned       items_sent;
  int unsigned       idle_cycles;
  bit                burst_mode;
  logic [CodeW-1:0]  text_q[$];
  string             col_names[3] = '{"Min", "Mid", "Max"};
  string             letter_pool  = "defrnoxMiadYmslcyz";

  aspect_ratio_attribute_parser dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  arap_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .fail_count_o  (fail_count),
    .pending_o     (pending_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic logic [CodeW-1:0] blank_unit();
    logic [CodeW-1:0] u;
    case ($urandom_range(0, 3))
      0:       u = 16'h0020;
      1:       u = 16'h0009;
      2:       u = 16'h000A;
      default: u = 16'h000D;
    endcase
    return u;
  endfunction

  function automatic logic [CodeW-1:0] random_unit();
    logic [CodeW-1:0] u;
    logic [7:0]       ch;
    ch = letter_pool[$urandom_range(0, letter_pool.len() - 1)];
    case ($urandom_range(0, 3))
      0:       u = CodeW'($urandom_range(0, 65535));
      1:       u = {8'h00, ch};
      2:       u = blank_unit();
      default: u = {8'($urandom_range(1, 255)), ch};
    endcase
    return u;
  endfunction

  function automatic void add_word(input string w);
    for (int i = 0; i < w.len(); i++) begin
      text_q.push_back({8'h00, w[i]});
    end
  endfunction

  function automatic void add_blanks(input int unsigned max_n);
    int unsigned n;
    n = $urandom_range(0, max_n);
    repeat (n) text_q.push_back(blank_unit());
  endfunction

  function automatic void build_wellformed();
    string tok;
    text_q.delete();
    add_blanks(2);
    if ($urandom_range(0, 3) == 0) begin
      add_word("defer");
      add_blanks(2);
    end
    if ($urandom_range(0, 5) == 0) begin
      add_word("none");
    end else begin
      tok = {"x", col_names[$urandom_range(0, 2)], "Y", col_names[$urandom_range(0, 2)]};
      add_word(tok);
    end
    add_blanks(2);
    case ($urandom_range(0, 2))
      0:       ;
      1:       add_word("meet");
      default: add_word("slice");
    endcase
    add_blanks(2);
  endfunction

  function automatic void corrupt_text();
    int unsigned idx;
    int unsigned keep;
    if (text_q.size() == 0) begin
      text_q.push_back(random_unit());
    end else begin
      idx = $urandom_range(0, text_q.size() - 1);
      case ($urandom_range(0, 3))
        0: text_q[idx] = random_unit();
        1: begin
          keep = $urandom_range(0, text_q.size() - 1);
          while (text_q.size() > keep) void'(text_q.pop_back());
        end
        2: text_q.insert(idx, random_unit());
        default: text_q[idx] = {8'($urandom_range(1, 255)), text_q[idx][7:0]};
      endcase
    end
  endfunction

  function automatic void build_noise();
    int unsigned n;
    text_q.delete();
    n = $urandom_range(0, 6);
    repeat (n) text_q.push_back(random_unit());
  endfunction

  task automatic send_unit(input logic [CodeW-1:0] cu, input logic hc, input logic lst);
    int unsigned gap;
    gap = burst_mode ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= cu;
    s_axis_tuser  <= hc;
    s_axis_tlast  <= lst;
    do @(posedge clk_i); while (!s_axis_tready);
    items_sent++;
  endtask

  task automatic send_text(input bit end_marker);
    bit split_end;
    split_end = end_marker || (text_q.size() == 0);
    for (int i = 0; i < text_q.size(); i++) begin
      if ($urandom_range(0, 9) == 0) begin
        send_unit(CodeW'($urandom_range(0, 65535)), 1'b0, 1'b0);
      end
      send_unit(text_q[i], 1'b1, !split_end && (i == text_q.size() - 1));
    end
    if (split_end) begin
      send_unit(CodeW'($urandom_range(0, 65535)), 1'b0, 1'b1);
    end
  endtask

  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      int unsigned stall;
      stall = burst_mode ? 0 : $urandom_range(0, 3);
      repeat (stall) begin
        m_axis_tready <= 1'b0;
        @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IdleLimit) begin
        $display("Test completed with failures");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int unsigned kind;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    s_axis_tlast  = 1'b0;
    items_sent    = 0;
    idle_cycles   = 0;
    burst_mode    = 1'b0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    text_q.delete();
    send_text(1'b0);
    text_q.delete();
    text_q.push_back(16'h0009);
    send_text(1'b0);
    text_q.delete();
    text_q.push_back(16'hFFFF);
    send_text(1'b0);
    text_q.delete();
    add_word("noneslice");
    send_text(1'b0);
    text_q.delete();
    add_word("defer ");
    send_text(1'b0);
    send_unit(16'hFFFF, 1'b0, 1'b0);
    text_q.delete();
    add_word("xMaxYMax");
    send_text(1'b1);

    while (items_sent < NumItems) begin
      burst_mode = ($urandom_range(0, 7) == 0);
      kind = $urandom_range(0, 9);
      if (kind < 6) begin
        build_wellformed();
      end else if (kind < 8) begin
        build_wellformed();
        corrupt_text();
      end else begin
        build_noise();
      end
      send_text($urandom_range(0, 4) == 0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_count != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
